[sv/cfr_pkg.sv]
package cfr_pkg;

  typedef enum logic [2:0] {
    CLS_ERR = 3'd0,
    CLS_REC = 3'd1,
    CLS_VER = 3'd2,
    CLS_SET = 3'd3,
    CLS_CHK = 3'd4
  } cls_t;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] end_byte;
    cls_t       cls;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int IDX_W       = 5;
  localparam int PIDX_W      = 4;

  localparam logic [7:0] CMD_RECOVERY = 8'h05;
  localparam logic [7:0] CMD_VERSION  = 8'h81;
  localparam logic [7:0] MASK_SETTING = 8'h50;
  localparam logic [7:0] MASK_CHECK   = 8'hA0;
  localparam logic [7:0] BYTE_RECOVER = 8'h55;
  localparam logic [7:0] BYTE_SETTING = 8'h55;
  localparam logic [7:0] LEN_BASE     = 8'd3;

  localparam logic [7:0] VERSION_SET [16] = '{
    8'h02, 8'h2C, 8'h01, 8'h2C, 8'h01, 8'h2C, 8'h01, 8'h2C,
    8'h01, 8'h2C, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'h00
  };

  localparam logic [7:0] CHECKOUT_SET [16] = '{
    8'h32, 8'h31, 8'h37, 8'h30, 8'h2E, 8'h30, 8'h30, 8'h30,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic cls_t classify(input logic [7:0] cmd);
    cls_t c;
    if (cmd == CMD_RECOVERY) begin
      c = CLS_REC;
    end else if (cmd == CMD_VERSION) begin
      c = CLS_VER;
    end else if ((cmd & MASK_SETTING) == MASK_SETTING) begin
      c = CLS_SET;
    end else if ((cmd & MASK_CHECK) == MASK_CHECK) begin
      c = CLS_CHK;
    end else begin
      c = CLS_ERR;
    end
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] param_count(input cls_t cls);
    logic [IDX_W-1:0] n;
    case (cls)
      CLS_REC: n = IDX_W'(1);
      CLS_VER: n = IDX_W'(14);
      CLS_SET: n = IDX_W'(1);
      CLS_CHK: n = IDX_W'(10);
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] param_byte(input cls_t cls, input logic [PIDX_W-1:0] i);
    logic [7:0] b;
    case (cls)
      CLS_REC: b = BYTE_RECOVER;
      CLS_VER: b = VERSION_SET[i];
      CLS_SET: b = BYTE_SETTING;
      CLS_CHK: b = CHECKOUT_SET[i];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[sv/command_frame_responder_unit.sv]
// Received bytes are taken one per cycle; only the end byte of a frame can be held
// off, and only while the two-entry reply queue is full.
// The end byte is written into the reply queue; the first beat is registered from
// its head; beats go one per cycle unless stalled: up to twenty, or one error beat.
// Reset is synchronous and active high; it returns the receiver to waiting for a head
// byte, empties the reply queue and drops any pending output beat.
module command_frame_responder_unit #(
  parameter int QueueDepth = cfr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       tx_valid,
  input  logic       tx_stall,
  output logic [7:0] tx_byte,
  output logic       frame_last,
  output logic       status
);
  import cfr_pkg::*;

  qstat_t qstat;
  desc_t  push_desc;
  desc_t  head_desc;
  logic   push;
  logic   pop;

  cfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_byte   (rx_byte),
    .qstat     (qstat),
    .push      (push),
    .push_desc (push_desc)
  );

  cfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .qstat     (qstat)
  );

  cfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (head_desc),
    .qstat      (qstat),
    .pop        (pop),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx_byte    (tx_byte),
    .frame_last (frame_last),
    .status     (status)
  );

  assert property (@(posedge clk) disable iff (rst) !(push && qstat.full))
    else $error("reply queue written while full");

  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("reply queue read while empty");

  assert property (@(posedge clk) disable iff (rst)
    (tx_valid && status) |-> (frame_last && tx_byte == 8'd0))
    else $error("error beat is not a lone zero beat");

  assert property (@(posedge clk) disable iff (rst)
    (qstat.empty && !tx_stall) |=> !tx_valid)
    else $error("output beat produced with nothing queued");

endmodule

[sv/cfr_front.sv]
module cfr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_stall,
  input  logic [7:0]     rx_byte,
  input  cfr_pkg::qstat_t qstat,
  output logic           push,
  output cfr_pkg::desc_t push_desc
);
  import cfr_pkg::*;

  typedef enum logic [6:0] {
    PH_HEAD  = 7'b0000001,
    PH_LEN   = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_CMD   = 7'b0001000,
    PH_PARAM = 7'b0010000,
    PH_CHK   = 7'b0100000,
    PH_END   = 7'b1000000
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] bytes_left;
  logic [7:0] saved_head;
  logic [7:0] saved_address;
  logic [7:0] saved_command;
  logic       accept;

  assign rx_stall = (phase == PH_END) && qstat.full;
  assign accept   = rx_valid && !rx_stall;
  assign push     = accept && (phase == PH_END);

  assign push_desc.head     = saved_head;
  assign push_desc.address  = saved_address;
  assign push_desc.command  = saved_command;
  assign push_desc.end_byte = rx_byte;
  assign push_desc.cls      = classify(saved_command);

  always_comb begin
    case (phase)
      PH_HEAD:  phase_next = PH_LEN;
      PH_LEN:   phase_next = PH_ADDR;
      PH_ADDR:  phase_next = PH_CMD;
      PH_CMD:   phase_next = (bytes_left != 8'd0) ? PH_PARAM : PH_CHK;
      PH_PARAM: phase_next = (bytes_left == 8'd1) ? PH_CHK : PH_PARAM;
      PH_CHK:   phase_next = PH_END;
      PH_END:   phase_next = PH_HEAD;
      default:  phase_next = PH_LEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      bytes_left <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_LEN) begin
        bytes_left <= (rx_byte >= LEN_BASE) ? rx_byte - LEN_BASE : 8'd0;
      end else if (phase == PH_PARAM) begin
        bytes_left <= bytes_left - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PH_HEAD: saved_head    <= rx_byte;
        PH_ADDR: saved_address <= rx_byte;
        PH_CMD:  saved_command <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

[sv/cfr_queue.sv]
module cfr_queue #(
  parameter int Depth = cfr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cfr_pkg::desc_t  push_desc,
  input  logic            pop,
  output cfr_pkg::desc_t  head_desc,
  output cfr_pkg::qstat_t qstat
);
  import cfr_pkg::*;

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  desc_t            entries [Depth];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(Depth));
  assign qstat.empty = (count == '0);
  assign head_desc   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[sv/cfr_back.sv]
module cfr_back (
  input  logic            clk,
  input  logic            rst,
  input  cfr_pkg::desc_t  desc,
  input  cfr_pkg::qstat_t qstat,
  output logic            pop,
  output logic            tx_valid,
  input  logic            tx_stall,
  output logic [7:0]      tx_byte,
  output logic            frame_last,
  output logic            status
);
  import cfr_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic [7:0]        sum;
  logic [IDX_W-1:0]  n;
  logic [PIDX_W-1:0] pidx;
  logic              load;
  logic              is_err;
  logic              last;
  logic [7:0]        byte_next;

  assign n      = param_count(desc.cls);
  assign pidx   = PIDX_W'(idx - IDX_W'(4));
  assign is_err = (desc.cls == CLS_ERR);
  assign load   = !qstat.empty && (!tx_valid || !tx_stall);
  assign last   = is_err || (idx == n + IDX_W'(5));
  assign pop    = load && last;

  always_comb begin
    if (is_err) begin
      byte_next = '0;
    end else if (idx == IDX_W'(0)) begin
      byte_next = desc.head;
    end else if (idx == IDX_W'(1)) begin
      byte_next = 8'(n) + LEN_BASE;
    end else if (idx == IDX_W'(2)) begin
      byte_next = desc.address;
    end else if (idx == IDX_W'(3)) begin
      byte_next = desc.command;
    end else if (idx < n + IDX_W'(4)) begin
      byte_next = param_byte(desc.cls, pidx);
    end else if (idx == n + IDX_W'(4)) begin
      byte_next = sum;
    end else begin
      byte_next = desc.end_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        tx_valid <= 1'b1;
        idx      <= last ? '0 : idx + IDX_W'(1);
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte    <= byte_next;
      frame_last <= last;
      status     <= is_err;
      sum        <= (idx == IDX_W'(0)) ? 8'd0 : sum + byte_next;
    end
  end

endmodule

[verif/cfr_checker.sv]
module cfr_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       tx_valid,
  input  logic       tx_stall,
  input  logic [7:0] tx_byte,
  input  logic       frame_last,
  input  logic       status,
  output int         fail_count,
  output int         pending
);
  import cfr_pkg::*;

  localparam logic [2:0] ST_HEAD   = 3'd0;
  localparam logic [2:0] ST_LEN    = 3'd1;
  localparam logic [2:0] ST_ADDR   = 3'd2;
  localparam logic [2:0] ST_CMD    = 3'd3;
  localparam logic [2:0] ST_PARAM  = 3'd4;
  localparam logic [2:0] ST_CHKSUM = 3'd5;
  localparam logic [2:0] ST_END    = 3'd6;

  localparam logic [7:0] RECOVERY_PARAM = 8'h55;
  localparam logic [7:0] SETTING_PARAM  = 8'h55;
  localparam logic [7:0] VERSION_PARAMS [14] = '{
    8'h02, 8'h2C, 8'h01, 8'h2C, 8'h01, 8'h2C, 8'h01,
    8'h2C, 8'h01, 8'h2C, 8'h12, 8'h34, 8'h56, 8'h78
  };
  localparam logic [7:0] CHECKOUT_PARAMS [10] = '{
    8'h32, 8'h31, 8'h37, 8'h30, 8'h2E, 8'h30, 8'h30, 8'h30, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } reply_beat_t;

  reply_beat_t reply_q[$];
  logic [2:0]  phase;
  logic [7:0]  skip_left;
  logic [7:0]  head_r;
  logic [7:0]  addr_r;
  logic [7:0]  cmd_r;
  int          fails = 0;

  function automatic cls_t command_class(input logic [7:0] c);
    if (c == 8'h05) return CLS_REC;
    if (c == 8'h81) return CLS_VER;
    if (c[6] && c[4]) return CLS_SET;
    if (c[7] && c[5]) return CLS_CHK;
    return CLS_ERR;
  endfunction

  task automatic queue_reply(input logic [7:0] end_b);
    logic [7:0]  params[$];
    logic [7:0]  len;
    logic [7:0]  sum;
    cls_t        k;
    k = command_class(cmd_r);
    case (k)
      CLS_REC: params.push_back(RECOVERY_PARAM);
      CLS_VER: foreach (VERSION_PARAMS[i]) params.push_back(VERSION_PARAMS[i]);
      CLS_SET: params.push_back(SETTING_PARAM);
      CLS_CHK: foreach (CHECKOUT_PARAMS[i]) params.push_back(CHECKOUT_PARAMS[i]);
      default: ;
    endcase
    if (k == CLS_ERR) begin
      reply_q.push_back('{8'h00, 1'b1, 1'b1});
    end else begin
      len = 8'(params.size() + 3);
      sum = len + addr_r + cmd_r;
      reply_q.push_back('{head_r, 1'b0, 1'b0});
      reply_q.push_back('{len, 1'b0, 1'b0});
      reply_q.push_back('{addr_r, 1'b0, 1'b0});
      reply_q.push_back('{cmd_r, 1'b0, 1'b0});
      foreach (params[i]) begin
        reply_q.push_back('{params[i], 1'b0, 1'b0});
        sum = sum + params[i];
      end
      reply_q.push_back('{sum, 1'b0, 1'b0});
      reply_q.push_back('{end_b, 1'b1, 1'b0});
    end
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    case (phase)
      ST_LEN: begin
        skip_left = (b >= 8'd3) ? b - 8'd3 : 8'd0;
        phase = ST_ADDR;
      end
      ST_ADDR: begin
        addr_r = b;
        phase = ST_CMD;
      end
      ST_CMD: begin
        cmd_r = b;
        phase = (skip_left != 8'd0) ? ST_PARAM : ST_CHKSUM;
      end
      ST_PARAM: begin
        skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) phase = ST_CHKSUM;
      end
      ST_CHKSUM: phase = ST_END;
      ST_END: begin
        phase = ST_HEAD;
        queue_reply(b);
      end
      default: begin
        head_r = b;
        phase = ST_LEN;
      end
    endcase
  endtask

  always @(posedge clk) begin
    reply_beat_t want;
    if (rst) begin
      phase = ST_HEAD;
      skip_left = 8'd0;
      head_r = 8'd0;
      addr_r = 8'd0;
      cmd_r = 8'd0;
      reply_q.delete();
      pending <= 0;
      fail_count <= fails;
    end else begin
      if (tx_valid && !tx_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: reply beat %h arrived with none expected", $time, tx_byte);
          fails++;
        end else begin
          want = reply_q.pop_front();
          if (tx_byte !== want.data) begin
            $display("%0t: tx_byte expected %h got %h", $time, want.data, tx_byte);
            fails++;
          end
          if (frame_last !== want.last) begin
            $display("%0t: frame_last expected %b got %b", $time, want.last, frame_last);
            fails++;
          end
          if (status !== want.err) begin
            $display("%0t: status expected %b got %b", $time, want.err, status);
            fails++;
          end
        end
      end
      if (rx_valid && !rx_stall) take_rx_byte(rx_byte);
      pending <= reply_q.size();
      fail_count <= fails;
    end
  end

endmodule

[verif/tb_command_frame_responder_unit.sv]
module tb_command_frame_responder_unit;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       tx_valid;
  logic       tx_stall = 1'b0;
  logic [7:0] tx_byte;
  logic       frame_last;
  logic       status;
  int         fail_count;
  int         pending;
  int         items_sent = 0;
  bit         src_calm = 1'b0;
  int         sink_hold = 0;
  int         cycle_no = 0;

  always #6 clk = ~clk;

  command_frame_responder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx_byte    (tx_byte),
    .frame_last (frame_last),
    .status     (status)
  );

  cfr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx_byte    (tx_byte),
    .frame_last (frame_last),
    .status     (status),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The reply side holds off at random after each beat and at times while idle, with calm stretches.
  always @(posedge clk) begin
    cycle_no++;
    if (rst) begin
      sink_hold = 0;
      tx_stall <= 1'b0;
    end else begin
      if (tx_valid && !tx_stall) begin
        sink_hold = ((cycle_no / 150) % 4 == 0) ? 0 : $urandom_range(0, 3);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end else if (!tx_valid && $urandom_range(0, 3) == 0) begin
        sink_hold = $urandom_range(1, 3);
      end
      tx_stall <= (sink_hold != 0);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (rx_stall);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] head, input logic [7:0] len,
                            input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] chk, input logic [7:0] end_b);
    int n;
    n = (len >= 8'd3) ? len - 3 : 0;
    send_byte(head);
    send_byte(len);
    send_byte(addr);
    send_byte(cmd);
    repeat (n) send_byte(8'($urandom));
    send_byte(chk);
    send_byte(end_b);
  endtask

  function automatic logic [7:0] pick_command();
    logic [7:0] c;
    c = 8'($urandom);
    case ($urandom_range(0, 4))
      0: c = 8'h05;
      1: c = 8'h81;
      2: c = c | 8'h50;
      3: begin
        c = c | 8'hA0;
        if ($urandom_range(0, 1)) c[4] = 1'b0;
        else c[6] = 1'b0;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic wait_replies_drained();
    rx_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int         frame_no;
    logic [7:0] len;
    frame_no = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_frame(8'hFF, 8'h00, 8'h00, 8'h05, 8'h00, 8'hFF);
    send_frame(8'h00, 8'h04, 8'hFF, 8'h81, 8'hFF, 8'h00);
    send_frame(8'h7E, 8'h02, 8'h5A, 8'h50, 8'h12, 8'h7E);
    send_frame(8'hAA, 8'h03, 8'h01, 8'hA0, 8'h34, 8'h0D);
    send_frame(8'h55, 8'h01, 8'h80, 8'h00, 8'h00, 8'hEF);
    send_frame(8'h12, 8'h00, 8'h34, 8'hFF, 8'h56, 8'h78);

    while (items_sent < 220) begin
      frame_no++;
      src_calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        if (frame_no == 5) len = 8'h60;
        else if ($urandom_range(0, 29) == 0) len = 8'($urandom_range(9, 40));
        else len = 8'($urandom_range(0, 8));
        send_frame(8'($urandom), len, 8'($urandom), pick_command(),
                   8'($urandom), 8'($urandom));
      end
      if (frame_no % 12 == 0) wait_replies_drained();
    end

    wait_replies_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("command_frame_responder_unit verification clean");
    end else begin
      $display("command_frame_responder_unit verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("command_frame_responder_unit verification failed");
    $finish;
  end

endmodule

[sim.f]
sv/cfr_pkg.sv
sv/cfr_front.sv
sv/cfr_queue.sv
sv/cfr_back.sv
sv/command_frame_responder_unit.sv
verif/cfr_checker.sv
verif/tb_command_frame_responder_unit.sv
